// ===== sv/mrs_pkg.sv =====
// shared constants, types and codes for the movement range search block
package mrs_pkg;

   localparam int NUM_TILES      = 1024;
   localparam int EDGE_SLOTS     = 8;
   localparam int COST_BITS      = 8;
   localparam int WEIGHT_BITS    = 4;
   localparam int TILE_BITS      = $clog2(NUM_TILES);
   localparam int SLOT_BITS      = $clog2(EDGE_SLOTS);
   localparam int COUNT_BITS     = TILE_BITS + 1;
   localparam int EDGE_ADDR_BITS = TILE_BITS + SLOT_BITS;
   localparam int EDGE_DEPTH     = NUM_TILES * EDGE_SLOTS;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [TILE_BITS-1:0]   target;
      logic [WEIGHT_BITS-1:0] weight;
   } edge_entry_type;

   typedef struct packed {
      logic                 mark;
      logic [COST_BITS-1:0] cost;
      logic [TILE_BITS-1:0] parent;
   } tile_entry_type;

   typedef enum logic [3:0] {
      ST_RESET_CLR,
      ST_IDLE,
      ST_QUERY_WAIT,
      ST_SEARCH_CLR,
      ST_START,
      ST_SCAN,
      ST_OPEN_WAIT,
      ST_COST_WAIT,
      ST_EDGE_RD,
      ST_EDGE_WAIT,
      ST_NB_WAIT
   } state_type;

endpackage

// ===== sv/mrs_if.sv =====
// request and response channel interfaces
interface mrs_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         op;
   logic [mrs_pkg::TILE_BITS-1:0]      tile;
   logic [mrs_pkg::SLOT_BITS-1:0]      slot;
   logic [mrs_pkg::TILE_BITS-1:0]      neighbour;
   logic [mrs_pkg::WEIGHT_BITS-1:0]    edge_cost;
   logic [mrs_pkg::COST_BITS-1:0]      move_range;

   modport source (output valid, op, tile, slot, neighbour, edge_cost, move_range,
                   input ready);
   modport sink   (input valid, op, tile, slot, neighbour, edge_cost, move_range,
                   output ready);
endinterface

interface mrs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               reached;
   logic [mrs_pkg::COST_BITS-1:0]      path_cost;
   logic [mrs_pkg::TILE_BITS-1:0]      parent_tile;
   logic [mrs_pkg::COUNT_BITS-1:0]     reached_count;

   modport source (output valid, reached, path_cost, parent_tile, reached_count,
                   input ready);
   modport sink   (input valid, reached, path_cost, parent_tile, reached_count,
                   output ready);
endinterface

// ===== sv/mrs_ram.sv =====
// generic single write port ram with registered read
module mrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/movement_range_search.sv =====
// movement range search: tile graph store, bucketed range search and tile query
//
//   channel  dir  contents
//   req_bus  in   op, tile, slot, neighbour, edge_cost, move_range
//   rsp_bus  out  reached, path_cost, parent_tile, reached_count
//
// edge write or unknown op: response registered on accept; query: a tile ram read,
// then the response. search: the marks of all 1024 tiles are cleared, then per step
// each open-list entry is read from the open ram and its cost from the tile ram, and
// each edge slot of an expanded tile is read; the one read port of the tile ram sets
// the pace. after reset the edge and tile rams are swept before the first word is
// taken. one word is in work at a time; a waiting response holds off the next request.
module movement_range_search (
   input  logic      clock,
   input  logic      reset,
   mrs_req_if.sink   req_bus,
   mrs_rsp_if.source rsp_bus
);
   import mrs_pkg::*;

   state_type state_ff, state_in;

   logic [EDGE_ADDR_BITS-1:0] clr_ff, clr_in;
   logic [COUNT_BITS-1:0]     idx_ff, idx_in;
   logic [COUNT_BITS-1:0]     len_ff, len_in;
   logic [COST_BITS-1:0]      step_ff, step_in;
   logic [COST_BITS-1:0]      budget_ff, budget_in;
   logic [SLOT_BITS-1:0]      slot_ff, slot_in;
   logic [TILE_BITS-1:0]      cur_ff, cur_in;
   logic [TILE_BITS-1:0]      start_ff, start_in;
   logic [TILE_BITS-1:0]      nb_ff, nb_in;
   logic [WEIGHT_BITS-1:0]    weight_ff, weight_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_reached_ff, rsp_reached_in;
   logic [COST_BITS-1:0]      rsp_cost_ff, rsp_cost_in;
   logic [TILE_BITS-1:0]      rsp_parent_ff, rsp_parent_in;
   logic [COUNT_BITS-1:0]     rsp_count_ff, rsp_count_in;

   logic                      edge_wr_en, edge_rd_en;
   logic [EDGE_ADDR_BITS-1:0] edge_wr_addr, edge_rd_addr;
   edge_entry_type            edge_wr_data, edge_rd_data;

   logic                      tile_wr_en, tile_rd_en;
   logic [TILE_BITS-1:0]      tile_wr_addr, tile_rd_addr;
   tile_entry_type            tile_wr_data, tile_rd_data;

   logic                      open_wr_en, open_rd_en;
   logic [TILE_BITS-1:0]      open_wr_addr, open_rd_addr;
   logic [TILE_BITS-1:0]      open_wr_data, open_rd_data;

   logic                      accept;
   logic                      next_slot;
   logic [COST_BITS:0]        new_cost;

   mrs_ram #(.WIDTH($bits(edge_entry_type)), .DEPTH(EDGE_DEPTH)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   mrs_ram #(.WIDTH($bits(tile_entry_type)), .DEPTH(NUM_TILES)) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_wr_en),
      .wr_addr (tile_wr_addr),
      .wr_data (tile_wr_data),
      .rd_en   (tile_rd_en),
      .rd_addr (tile_rd_addr),
      .rd_data (tile_rd_data)
   );

   mrs_ram #(.WIDTH(TILE_BITS), .DEPTH(NUM_TILES)) u_open_ram (
      .clock   (clock),
      .wr_en   (open_wr_en),
      .wr_addr (open_wr_addr),
      .wr_data (open_wr_data),
      .rd_en   (open_rd_en),
      .rd_addr (open_rd_addr),
      .rd_data (open_rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.reached       = rsp_reached_ff;
   assign rsp_bus.path_cost     = rsp_cost_ff;
   assign rsp_bus.parent_tile   = rsp_parent_ff;
   assign rsp_bus.reached_count = rsp_count_ff;

   assign new_cost = {1'b0, step_ff} + {{(COST_BITS + 1 - WEIGHT_BITS){1'b0}}, weight_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RESET_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      step_ff        <= step_in;
      budget_ff      <= budget_in;
      slot_ff        <= slot_in;
      cur_ff         <= cur_in;
      start_ff       <= start_in;
      nb_ff          <= nb_in;
      weight_ff      <= weight_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_parent_ff  <= rsp_parent_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      idx_in         = idx_ff;
      len_in         = len_ff;
      step_in        = step_ff;
      budget_in      = budget_ff;
      slot_in        = slot_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      nb_in          = nb_ff;
      weight_in      = weight_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_reached_in = rsp_reached_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_count_in   = rsp_count_ff;

      edge_wr_en   = 1'b0;
      edge_wr_addr = clr_ff;
      edge_wr_data = '0;
      edge_rd_en   = 1'b0;
      edge_rd_addr = {cur_ff, slot_ff};
      tile_wr_en   = 1'b0;
      tile_wr_addr = clr_ff[TILE_BITS-1:0];
      tile_wr_data = '0;
      tile_rd_en   = 1'b0;
      tile_rd_addr = cur_ff;
      open_wr_en   = 1'b0;
      open_wr_addr = len_ff[TILE_BITS-1:0];
      open_wr_data = nb_ff;
      open_rd_en   = 1'b0;
      open_rd_addr = idx_ff[TILE_BITS-1:0];
      next_slot    = 1'b0;

      unique case (state_ff)
         ST_RESET_CLR: begin
            edge_wr_en = 1'b1;
            tile_wr_en = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == EDGE_ADDR_BITS'(EDGE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_reached_in = 1'b0;
               rsp_cost_in    = '0;
               rsp_parent_in  = '0;
               rsp_count_in   = '0;
               unique case (req_bus.op)
                  OP_WRITE: begin
                     edge_wr_en          = 1'b1;
                     edge_wr_addr        = {req_bus.tile, req_bus.slot};
                     edge_wr_data.target = req_bus.neighbour;
                     edge_wr_data.weight = req_bus.edge_cost;
                     rsp_valid_in        = 1'b1;
                  end
                  OP_SEARCH: begin
                     start_in  = req_bus.tile;
                     budget_in = req_bus.move_range;
                     clr_in    = '0;
                     len_in    = '0;
                     state_in  = ST_SEARCH_CLR;
                  end
                  OP_QUERY: begin
                     tile_rd_en   = 1'b1;
                     tile_rd_addr = req_bus.tile;
                     state_in     = ST_QUERY_WAIT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_QUERY_WAIT: begin
            if (tile_rd_data.mark) begin
               rsp_reached_in = 1'b1;
               rsp_cost_in    = tile_rd_data.cost;
               rsp_parent_in  = tile_rd_data.parent;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEARCH_CLR: begin
            tile_wr_en = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff[TILE_BITS-1:0] == TILE_BITS'(NUM_TILES - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            tile_wr_en          = 1'b1;
            tile_wr_addr        = start_ff;
            tile_wr_data.mark   = 1'b1;
            tile_wr_data.cost   = '0;
            tile_wr_data.parent = start_ff;
            open_wr_en          = 1'b1;
            open_wr_addr        = '0;
            open_wr_data        = start_ff;
            len_in              = COUNT_BITS'(1);
            idx_in              = '0;
            step_in             = '0;
            if (budget_ff == '0) begin
               rsp_count_in = COUNT_BITS'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff >= len_ff) begin
               // end of one cost bucket
               idx_in  = '0;
               step_in = step_ff + 1'b1;
               if (step_ff + 1'b1 == budget_ff) begin
                  rsp_count_in = len_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               open_rd_en = 1'b1;
               state_in   = ST_OPEN_WAIT;
            end
         end
         ST_OPEN_WAIT: begin
            cur_in       = open_rd_data;
            tile_rd_en   = 1'b1;
            tile_rd_addr = open_rd_data;
            state_in     = ST_COST_WAIT;
         end
         ST_COST_WAIT: begin
            if (tile_rd_data.cost != step_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               slot_in  = '0;
               state_in = ST_EDGE_RD;
            end
         end
         ST_EDGE_RD: begin
            edge_rd_en = 1'b1;
            state_in   = ST_EDGE_WAIT;
         end
         ST_EDGE_WAIT: begin
            nb_in     = edge_rd_data.target;
            weight_in = edge_rd_data.weight;
            if (edge_rd_data.weight == '0) begin
               next_slot = 1'b1;
            end else begin
               tile_rd_en   = 1'b1;
               tile_rd_addr = edge_rd_data.target;
               state_in     = ST_NB_WAIT;
            end
         end
         ST_NB_WAIT: begin
            next_slot = 1'b1;
            // first discovery within budget fixes cost and parent
            if (!tile_rd_data.mark && new_cost <= {1'b0, budget_ff}
                && len_ff < COUNT_BITS'(NUM_TILES)) begin
               tile_wr_en          = 1'b1;
               tile_wr_addr        = nb_ff;
               tile_wr_data.mark   = 1'b1;
               tile_wr_data.cost   = new_cost[COST_BITS-1:0];
               tile_wr_data.parent = cur_ff;
               open_wr_en          = 1'b1;
               len_in              = len_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (next_slot) begin
         if (slot_ff == SLOT_BITS'(EDGE_SLOTS - 1)) begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
         end else begin
            slot_in  = slot_ff + 1'b1;
            state_in = ST_EDGE_RD;
         end
      end
   end

endmodule

// ===== test/mrs_checker.sv =====
// checker for the movement range search block: predicts every response word and compares
module mrs_checker (
   input  logic clock,
   input  logic reset,
   mrs_req_if   req_bus,
   mrs_rsp_if   rsp_bus,
   output int   failures,
   output int   pending
);
   import mrs_pkg::*;

   typedef struct {
      logic                  reached;
      logic [COST_BITS-1:0]  path_cost;
      logic [TILE_BITS-1:0]  parent_tile;
      logic [COUNT_BITS-1:0] reached_count;
   } tile_answer_type;

   logic [TILE_BITS-1:0]   link_target [EDGE_DEPTH];
   logic [WEIGHT_BITS-1:0] link_weight [EDGE_DEPTH];
   bit                     seen        [NUM_TILES];
   int                     best_cost   [NUM_TILES];
   int                     came_from   [NUM_TILES];
   int                     found_order [NUM_TILES];
   int                     found_count;
   tile_answer_type        due_answers [$];

   initial begin
      for (int a = 0; a < EDGE_DEPTH; a++) begin
         link_target[a] = '0;
         link_weight[a] = '0;
      end
      for (int t = 0; t < NUM_TILES; t++) begin
         seen[t] = 0;
         best_cost[t] = 0;
         came_from[t] = 0;
      end
      found_count = 0;
   end

   // bucket flood: per step expand the tiles of that cost in discovery order
   function automatic int flood_range(int start, int budget);
      int here, nb, c, a;
      for (int t = 0; t < NUM_TILES; t++) seen[t] = 0;
      seen[start] = 1;
      best_cost[start] = 0;
      came_from[start] = start;
      found_order[0] = start;
      found_count = 1;
      for (int step = 0; step < budget; step++) begin
         for (int i = 0; i < found_count; i++) begin
            here = found_order[i];
            if (best_cost[here] != step) continue;
            for (int s = 0; s < EDGE_SLOTS; s++) begin
               a = here * EDGE_SLOTS + s;
               nb = link_target[a];
               if (link_weight[a] == 0 || seen[nb]) continue;
               c = best_cost[here] + link_weight[a];
               if (c > budget) continue;
               seen[nb] = 1;
               best_cost[nb] = c;
               came_from[nb] = here;
               if (found_count < NUM_TILES) begin
                  found_order[found_count] = nb;
                  found_count++;
               end
            end
         end
      end
      return found_count;
   endfunction

   function automatic tile_answer_type answer_request(logic [1:0] op, int tile, int slot,
                                                       int nb, int w, int budget);
      tile_answer_type r;
      r = '{reached: 0, path_cost: '0, parent_tile: '0, reached_count: '0};
      case (op)
         OP_WRITE: begin
            link_target[tile * EDGE_SLOTS + slot] = TILE_BITS'(nb);
            link_weight[tile * EDGE_SLOTS + slot] = WEIGHT_BITS'(w);
         end
         OP_SEARCH: r.reached_count = COUNT_BITS'(flood_range(tile, budget));
         OP_QUERY: begin
            if (seen[tile]) begin
               r.reached = 1;
               r.path_cost = COST_BITS'(best_cost[tile]);
               r.parent_tile = TILE_BITS'(came_from[tile]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      tile_answer_type want;
      int inc, dec;
      inc = 0;
      dec = 0;
      if (reset) begin
         failures <= 0;
         pending <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_answers.push_back(answer_request(req_bus.op, req_bus.tile, req_bus.slot,
                                                 req_bus.neighbour, req_bus.edge_cost,
                                                 req_bus.move_range));
            inc = 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            dec = 1;
            if (due_answers.size() == 0) begin
               $error("response word with nothing expected");
               failures <= failures + 1;
            end else begin
               want = due_answers.pop_front();
               if (want.reached !== rsp_bus.reached ||
                   want.path_cost !== rsp_bus.path_cost ||
                   want.parent_tile !== rsp_bus.parent_tile ||
                   want.reached_count !== rsp_bus.reached_count)
                  failures <= failures + 1;
               if (want.reached !== rsp_bus.reached)
                  $error("reached expected %0d got %0d", want.reached, rsp_bus.reached);
               if (want.path_cost !== rsp_bus.path_cost)
                  $error("path_cost expected %0d got %0d", want.path_cost,
                         rsp_bus.path_cost);
               if (want.parent_tile !== rsp_bus.parent_tile)
                  $error("parent_tile expected %0d got %0d", want.parent_tile,
                         rsp_bus.parent_tile);
               if (want.reached_count !== rsp_bus.reached_count)
                  $error("reached_count expected %0d got %0d", want.reached_count,
                         rsp_bus.reached_count);
            end
         end
         pending <= pending + inc - dec;
      end
   end

endmodule

// ===== test/movement_range_search_test.sv =====
// stimulus and verdict for the movement range search block
module movement_range_search_test;
   import mrs_pkg::*;

   logic clock;
   logic reset;
   logic quiet;
   logic req_taken;
   int   failures;
   int   pending;
   int   sent;
   int   pool [40];

   mrs_req_if req_bus ();
   mrs_rsp_if rsp_bus ();

   movement_range_search dut (.clock(clock), .reset(reset), .req_bus(req_bus),
                              .rsp_bus(rsp_bus));

   mrs_checker check (.clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
                      .failures(failures), .pending(pending));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) req_taken <= req_bus.valid && req_bus.ready;

   always @(negedge clock)
      rsp_bus.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);

   task automatic send_word(logic [1:0] op, int tile, int slot, int nb, int w, int budget);
      while (!quiet && $urandom_range(0, 99) < 18) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.tile       <= TILE_BITS'(tile);
      req_bus.slot       <= SLOT_BITS'(slot);
      req_bus.neighbour  <= TILE_BITS'(nb);
      req_bus.edge_cost  <= WEIGHT_BITS'(w);
      req_bus.move_range <= COST_BITS'(budget);
      do @(negedge clock); while (!req_taken);
      sent++;
   endtask

   task automatic send_random_word();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 45)
         send_word(OP_WRITE, pool[$urandom_range(0, 39)], $urandom_range(0, 7),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                               : pool[$urandom_range(0, 39)],
                   $urandom_range(0, 15), $urandom_range(0, 255));
      else if (kind < 60)
         send_word(OP_SEARCH, pool[$urandom_range(0, 39)], $urandom_range(0, 7),
                   $urandom_range(0, 1023), $urandom_range(0, 15),
                   ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 40));
      else if (kind < 90)
         send_word(OP_QUERY, pool[$urandom_range(0, 39)], $urandom_range(0, 7),
                   $urandom_range(0, 1023), $urandom_range(0, 15), $urandom_range(0, 255));
      else
         // noise: unknown op or a query on any tile
         send_word(($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_QUERY,
                   $urandom_range(0, 1023),
                   $urandom_range(0, 7), $urandom_range(0, 1023), $urandom_range(0, 15),
                   $urandom_range(0, 255));
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      quiet = 1'b0;
      sent = 0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_WRITE;
      req_bus.tile = '0;
      req_bus.slot = '0;
      req_bus.neighbour = '0;
      req_bus.edge_cost = '0;
      req_bus.move_range = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < 40; i++) pool[i] = $urandom_range(0, 1023);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(OP_WRITE, 0, 0, 1, 1, 0);
      send_word(OP_WRITE, 0, 7, 1023, 15, 255);
      send_word(OP_WRITE, 1, 3, 0, 2, 0);        // edge back to the start
      send_word(OP_WRITE, 1, 4, 2, 1, 0);
      send_word(OP_WRITE, 1023, 1, 2, 3, 0);     // second way into tile 2
      send_word(OP_WRITE, 2, 0, 1, 0, 0);        // empty slot
      send_word(OP_SEARCH, 0, 0, 0, 0, 0);
      send_word(OP_QUERY, 0, 0, 0, 0, 0);
      send_word(OP_QUERY, 1, 0, 0, 0, 0);
      send_word(OP_SEARCH, 0, 0, 0, 0, 255);
      send_word(OP_QUERY, 0, 0, 0, 0, 0);
      send_word(OP_QUERY, 1, 0, 0, 0, 0);
      send_word(OP_QUERY, 2, 0, 0, 0, 0);
      send_word(OP_QUERY, 1023, 0, 0, 0, 0);
      send_word(OP_QUERY, 5, 0, 0, 0, 0);
      send_word(OP_UNUSED, 1023, 7, 1023, 15, 255);
      send_word(OP_SEARCH, 1023, 0, 0, 0, 255);
      send_word(OP_QUERY, 1023, 0, 0, 0, 0);
      send_word(OP_QUERY, 1, 0, 0, 0, 0);
      send_word(OP_WRITE, 0, 7, 1023, 0, 0);
      send_word(OP_SEARCH, 0, 0, 0, 0, 1);      // cost equal to the budget
      send_word(OP_QUERY, 1, 0, 0, 0, 0);
      send_word(OP_QUERY, 1023, 0, 0, 0, 0);

      while (sent < 140) begin
         quiet = (sent >= 80 && sent < 110);
         send_random_word();
      end
      quiet = 1'b0;
      @(negedge clock);
      req_bus.valid <= 1'b0;

      guard = 0;
      while (pending != 0 && guard < 2_000_000) begin
         @(negedge clock);
         guard++;
      end
      repeat (50) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
